// ----- rtl/core/rmts_pkg.sv -----
// shared constants and types of the rate-monotonic tick scheduler
// no dependencies; imported by every module of the core

package rmts_pkg;

   localparam int MAX_TASKS      = 4;
   localparam int DEF_TASK_COUNT = 4;
   localparam int DEF_TIME_BITS  = 16;

   localparam int PERIOD_BITS    = 16;
   localparam int BUDGET_BITS    = 16;
   localparam int TASK_BITS      = 3;
   localparam int MASK_BITS      = 4;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PERIOD_A = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BUDGET_A = 3'd4;

   localparam logic [TASK_BITS-1:0] TASK_IDLE = 3'd0;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                   valid;
      logic [PERIOD_BITS-1:0] period;
      logic [TASK_BITS-1:0]   task_num;
   } rmts_pick_type;

   // per-cell register write
   typedef struct packed {
      logic                   period_we;
      logic                   budget_we;
      logic [CSR_DATA_BITS-1:0] data;
   } rmts_csr_type;

   // tick control broadcast to all cells
   typedef struct packed {
      logic                 step;
      logic                 restart;
      logic [TASK_BITS-1:0] winner;
   } rmts_tick_type;

endpackage

// ----- rtl/core/rate_monotonic_tick_scheduler_core.sv -----
// top level of the rate-monotonic tick scheduler: a row of task cells,
// register decode and the result buffer; depends on rmts_pkg, rmts_cell, rmts_out_buf
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | tdata[0] restart, [7:1] zero
//   rsp     | out       | rsp_tvalid/tready   | tdata[2:0] running_task,
//           |           |                     |   [6:3] released_mask, [7] idle
//   csr     | in        | csr_valid/ready     | csr_index register, csr_data value
//
// one tick per cycle while req_tready is high; its result is registered in the result buffer.
// the tick runs through the priority chain of all cells combinationally,
// which sets the rate and the clock.
// reset: periods 1, budgets 0, all counters and budgets left cleared.
// a two-word result buffer keeps req_tready high while one result waits;
// req_tready drops only when two results are unclaimed. csr_ready is always high.

module rate_monotonic_tick_scheduler_core
   import rmts_pkg::*;
#(
   parameter int TASK_COUNT = DEF_TASK_COUNT,
   parameter int TIME_BITS  = DEF_TIME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // [0] restart
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [2:0] running_task, [6:3] released_mask, [7] idle
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   rmts_pick_type            pick [TASK_COUNT+1];
   rmts_csr_type             cell_csr [TASK_COUNT];
   logic [TASK_COUNT-1:0]    rel_bits;
   rmts_tick_type            tick;
   logic                     has_room;
   logic                     csr_we;
   logic [TASK_BITS-1:0]     running;
   logic [MASK_BITS-1:0]     rel_mask;
   logic                     idle;
   logic [RSP_DATA_BITS-1:0] result;

   assign csr_ready  = 1'b1;
   assign csr_we     = csr_valid && csr_ready;
   assign req_tready = has_room;
   assign pick[0]    = '0;

   always_comb begin
      tick.step    = req_tvalid && req_tready;
      tick.restart = req_tdata[0];
      running      = pick[TASK_COUNT].valid ? pick[TASK_COUNT].task_num : TASK_IDLE;
      tick.winner  = running;
      idle         = !pick[TASK_COUNT].valid;
      rel_mask     = MASK_BITS'(rel_bits);
      result       = {idle, rel_mask, running};
   end

   for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
      assign cell_csr[i].period_we =
         csr_we && (csr_index == REG_PERIOD_A + CSR_INDEX_BITS'(i));
      assign cell_csr[i].budget_we =
         csr_we && (csr_index == REG_BUDGET_A + CSR_INDEX_BITS'(i));
      assign cell_csr[i].data = csr_data;

      rmts_cell #(
         .TIME_BITS (TIME_BITS),
         .TASK_NUM  (TASK_BITS'(i + 1))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .csr      (cell_csr[i]),
         .tick     (tick),
         .pick_in  (pick[i]),
         .pick_out (pick[i+1]),
         .released (rel_bits[i])
      );
   end

   rmts_out_buf #(
      .WIDTH (RSP_DATA_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (tick.step),
      .push_data (result),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// ----- rtl/core/rmts_cell.sv -----
// one task cell: period and budget registers, phase counter, budget left,
// and one link of the priority chain; depends on rmts_pkg

module rmts_cell
   import rmts_pkg::*;
#(
   parameter int                   TIME_BITS = DEF_TIME_BITS,
   parameter logic [TASK_BITS-1:0] TASK_NUM  = 3'd1
) (
   input  logic          clock,
   input  logic          reset,
   input  rmts_csr_type  csr,
   input  rmts_tick_type tick,
   input  rmts_pick_type pick_in,
   output rmts_pick_type pick_out,
   output logic          released
);

   localparam int CMP_BITS = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

   logic [PERIOD_BITS-1:0] period_ff;
   logic [BUDGET_BITS-1:0] budget_ff;
   logic [TIME_BITS-1:0]   phase_ff;
   logic [TIME_BITS-1:0]   phase_in;
   logic [BUDGET_BITS-1:0] left_ff;
   logic [BUDGET_BITS-1:0] left_in;

   logic [PERIOD_BITS-1:0] eff_period;
   logic [TIME_BITS-1:0]   phase_cur;
   logic [TIME_BITS-1:0]   phase_inc;
   logic [BUDGET_BITS-1:0] left_cur;
   logic                   ready_to_run;
   logic                   takes_lead;
   logic                   picked;

   always_comb begin
      eff_period   = (period_ff == '0) ? PERIOD_BITS'(1) : period_ff;
      phase_cur    = tick.restart ? '0 : phase_ff;
      released     = (phase_cur == '0);
      // a restart always releases, so the cleared budget is reloaded anyway
      left_cur     = released ? budget_ff : left_ff;
      ready_to_run = (left_cur != '0);
      // strict compare: an earlier cell keeps a tie
      takes_lead   = ready_to_run && (!pick_in.valid || (eff_period < pick_in.period));

      if (takes_lead) begin
         pick_out.valid    = 1'b1;
         pick_out.period   = eff_period;
         pick_out.task_num = TASK_NUM;
      end else begin
         pick_out = pick_in;
      end

      picked    = (tick.winner == TASK_NUM);
      left_in   = picked ? (left_cur - BUDGET_BITS'(1)) : left_cur;
      phase_inc = phase_cur + TIME_BITS'(1);
      if (CMP_BITS'(phase_inc) >= CMP_BITS'(eff_period)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_BITS'(1);
         budget_ff <= '0;
         phase_ff  <= '0;
         left_ff   <= '0;
      end else begin
         if (csr.period_we) begin
            period_ff <= csr.data;
         end
         if (csr.budget_we) begin
            budget_ff <= csr.data;
         end
         if (tick.step) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
      end
   end

endmodule

// ----- rtl/core/rmts_out_buf.sv -----
// two-word result buffer between the cell row and the result channel
// depends on rmts_pkg

module rmts_out_buf
   import rmts_pkg::*;
#(
   parameter int WIDTH = RSP_DATA_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic             pop;

   always_comb begin
      has_room  = (count_ff != 2'd2);
      out_valid = (count_ff != 2'd0);
      out_data  = entry_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

// ----- rtl/core/rmts_checker.sv -----
// port-level checks of the rate-monotonic tick scheduler core
// depends on rmts_pkg; bound to rate_monotonic_tick_scheduler_core below

module rmts_checker
   import rmts_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a waiting word is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a tick taken with nothing queued shows up on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid)
      else $error("accepted tick produced no result word");

   // an empty buffer never blocks the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result buffer");

   // idle flag agrees with the task number, which is 0 to 4
   a_idle_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7] == (rsp_tdata[2:0] == TASK_IDLE))
                     && (rsp_tdata[2:0] <= 3'd4))
      else $error("idle flag and running task disagree");

   // nothing is presented straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (.*);
